FILE: rtl/grid_bbox_candidate_index_unit_macros.svh
// Assertion macros for the grid bounding-box candidate index unit.
// Used by the top level; needs clk and rst_n in the scope of each use.
`ifndef GRID_BBOX_CANDIDATE_INDEX_UNIT_MACROS_SVH
`define GRID_BBOX_CANDIDATE_INDEX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GBCI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GBCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GBCI_ASSERT_NOW(lbl, ante, cons, msg)
`define GBCI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/gbci_pkg.sv
// Shared types, constants and helper functions of the grid bbox index unit.
// No dependencies; every module and interface file imports this package.
`default_nettype none

package gbci_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int FUNC_W      = 2;
  localparam int LON_W       = 25;
  localparam int LAT_W       = 24;
  localparam int CS_W        = 8;
  localparam int STATUS_W    = 3;
  localparam int FRAC_W      = 16;
  localparam int DEG_W       = 9;
  localparam int LON_CELL_W  = 9;
  localparam int LAT_CELL_W  = 8;
  localparam int DIV_STEPS   = 9;
  localparam int DIV_CNT_W   = 4;
  localparam int NUM_OPS     = 4;
  localparam int OPI_W       = 2;
  localparam int OPS_ADD     = 4;
  localparam int OPS_QUERY   = 2;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int EXT_W       = 26;

  localparam logic signed [EXT_W-1:0] LON_LIMIT = 26'sd11796480;
  localparam logic signed [EXT_W-1:0] LAT_LIMIT = 26'sd5898240;

  // Function codes of an input beat.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MATCH    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NO_MATCH = 3'd4;

  // Register index, taken from the word address bit.
  localparam logic REG_CELL_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD,
    ST_EMIT,
    ST_SCAN,
    ST_FIN
  } gbci_state_t;

  typedef struct packed {
    logic [LON_CELL_W-1:0] lon_lo;
    logic [LON_CELL_W-1:0] lon_hi;
    logic [LAT_CELL_W-1:0] lat_lo;
    logic [LAT_CELL_W-1:0] lat_hi;
  } gbci_box_t;

  typedef struct packed {
    logic shift;
    logic load;
  } gbci_cell_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DEG_W-1:0] quo;
  } gbci_div_stat_t;

  // Saturate a longitude to +-180 degrees, shift by 180, keep whole degrees.
  function automatic logic [DEG_W-1:0] lon_degrees(input logic signed [LON_W-1:0] x);
    logic signed [EXT_W-1:0] xs;
    logic signed [EXT_W-1:0] v;
    xs = {x[LON_W-1], x};
    if (xs < -LON_LIMIT) begin
      v = '0;
    end else if (xs > LON_LIMIT) begin
      v = LON_LIMIT + LON_LIMIT;
    end else begin
      v = xs + LON_LIMIT;
    end
    return v[FRAC_W+DEG_W-1:FRAC_W];
  endfunction

  // Same for latitude with a 90 degree limit.
  function automatic logic [DEG_W-1:0] lat_degrees(input logic signed [LAT_W-1:0] x);
    logic signed [EXT_W-1:0] xs;
    logic signed [EXT_W-1:0] v;
    xs = {{(EXT_W-LAT_W){x[LAT_W-1]}}, x};
    if (xs < -LAT_LIMIT) begin
      v = '0;
    end else if (xs > LAT_LIMIT) begin
      v = LAT_LIMIT + LAT_LIMIT;
    end else begin
      v = xs + LAT_LIMIT;
    end
    return {1'b0, v[FRAC_W+LAT_CELL_W-1:FRAC_W]};
  endfunction

  function automatic logic box_hit(input gbci_box_t b,
                                   input logic [LON_CELL_W-1:0] pc,
                                   input logic [LAT_CELL_W-1:0] pr);
    return (b.lon_lo <= pc) && (pc <= b.lon_hi) && (b.lat_lo <= pr) && (pr <= b.lat_hi);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gbci_chan_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on gbci_pkg for field widths.
`default_nettype none

interface gbci_in_if;
  import gbci_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [LON_W-1:0]  box_lon_min;
  logic signed [LON_W-1:0]  box_lon_max;
  logic signed [LAT_W-1:0]  box_lat_min;
  logic signed [LAT_W-1:0]  box_lat_max;
  logic signed [LON_W-1:0]  point_lon;
  logic signed [LAT_W-1:0]  point_lat;

  modport source (output valid, func, box_lon_min, box_lon_max, box_lat_min,
                  box_lat_max, point_lon, point_lat, input ready);
  modport sink (input valid, func, box_lon_min, box_lon_max, box_lat_min,
                box_lat_max, point_lon, point_lat, output ready);
endinterface

interface gbci_out_if;
  import gbci_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    region_index;
  logic                last;

  modport source (output valid, status, region_index, last, input ready);
  modport sink (input valid, status, region_index, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/grid_bbox_candidate_index_unit.sv
// Uniform-grid bounding-box candidate index, top level.
// Depends on gbci_pkg, gbci_chan_if, gbci_cell, gbci_div and the macros header.
//
// The unit keeps up to 64 regions, each reduced to the grid-cell ranges of its
// bounding box, and answers point queries with the ascending list of region
// indexes whose ranges contain the point's cell. A clear beat empties the table
// and returns one "cleared" result. An add beat saturates the four box
// coordinates, converts them to cells with the cell size in force at that
// moment, stores them under the next index and returns that index; once 64
// regions are stored an add returns "table full" and stores nothing. A query
// beat returns one "match" result per containing region, the final one with
// last set, or a single "no match" result. Function code 3 is dropped without a
// result. A cell size of zero behaves as one. The regions live in a ring of 64
// cells that rotates by one cell per cycle during a query, save while a new
// match must displace a held one the output register cannot take; the region
// at the head of the ring is compared against the point's cell each cycle,
// and a full turn puts every region back in its home cell. Cell numbers come
// from one shared divider that produces one quotient bit per cycle. An add
// divides its four coordinates in turn, a query its two before one turn of the
// ring and the closing result; a beat is held up only while the result side
// holds off. One beat is worked on at a time; the input is ready whenever the
// unit is idle, even while the last result still sits in the output register.
// The cell_size register is at byte address 0 of the APB port. The user must see
// that it is written only while the unit is idle; the block does not enforce it.
`default_nettype none
`include "grid_bbox_candidate_index_unit_macros.svh"

module grid_bbox_candidate_index_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  gbci_in_if.sink                     in_bus,
  gbci_out_if.source                  out_bus,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbci_pkg::ADDR_W-1:0] paddr,
  input  logic [gbci_pkg::DATA_W-1:0] pwdata,
  output logic [gbci_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import gbci_pkg::*;

  // Configuration register.
  logic [CS_W-1:0] cell_size_r;
  logic [CS_W-1:0] cs_eff;
  logic            cfg_wr;
  logic            reg_sel;

  // Sequencer state.
  gbci_state_t     state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [OPI_W-1:0]  opi_r, opi_nxt;
  logic              run_r, run_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [STATUS_W-1:0] stg_status_r, stg_status_nxt;
  logic [IDX_W-1:0]    stg_idx_r, stg_idx_nxt;
  logic [DEG_W-1:0]  deg_r [NUM_OPS];
  logic [DEG_W-1:0]  deg_nxt [NUM_OPS];
  logic [DEG_W-1:0]  quo_r [NUM_OPS];
  logic [DEG_W-1:0]  quo_nxt [NUM_OPS];

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;
  logic                out_free;
  logic                push;
  logic [STATUS_W-1:0] push_status;
  logic [IDX_W-1:0]    push_idx;
  logic                push_last;

  // Datapath links.
  logic           in_ready;
  logic           div_start;
  gbci_div_stat_t div_stat;
  logic           add_load;
  logic           scan_adv;
  logic           last_op;
  logic           hit;
  gbci_box_t      new_box;
  gbci_box_t      cell_box [MAX_REGIONS];
  gbci_cell_ctl_t cell_ctl [MAX_REGIONS];

  // ---------------------------------------------------------------------------
  // APB register port. The word index is the address bit above the byte lanes.
  // ---------------------------------------------------------------------------
  assign reg_sel = paddr[ADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_CELL_SIZE) ? DATA_W'(cell_size_r) : '0;
  assign cs_eff  = (cell_size_r == '0) ? CS_W'(1) : cell_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CS_W'(1);
    end else if (cfg_wr && (reg_sel == REG_CELL_SIZE)) begin
      cell_size_r <= pwdata[CS_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: whole degrees of the current coordinate over the cell size.
  // ---------------------------------------------------------------------------
  gbci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (deg_r[opi_r]),
    .divisor  (cs_eff),
    .stat     (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Region ring. At rest cell k holds region k. During a query every cell takes
  // its upper neighbor's box each advancing cycle and cell 0 wraps to the top,
  // so region "step" sits in cell 0 when it is compared.
  // ---------------------------------------------------------------------------
  assign new_box.lon_lo = quo_r[0];
  assign new_box.lon_hi = quo_r[1];
  assign new_box.lat_lo = quo_r[2][LAT_CELL_W-1:0];
  assign new_box.lat_hi = quo_r[3][LAT_CELL_W-1:0];

  for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_ring
    localparam int NEXT = (k + 1) % MAX_REGIONS;
    assign cell_ctl[k].shift = scan_adv;
    assign cell_ctl[k].load  = add_load && (count_r[IDX_W-1:0] == IDX_W'(k));
    gbci_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[k]),
      .load_box (new_box),
      .shift_in (cell_box[NEXT]),
      .box      (cell_box[k])
    );
  end

  // Only regions below the fill count take part; the rest hold stale data.
  assign hit = (step_r < count_r) &&
               box_hit(cell_box[0], quo_r[0], quo_r[1][LAT_CELL_W-1:0]);

  assign last_op  = (func_r == FUNC_ADD) ? (opi_r == OPI_W'(OPS_ADD - 1))
                                         : (opi_r == OPI_W'(OPS_QUERY - 1));
  assign out_free = !out_valid_r || out_bus.ready;

  // ---------------------------------------------------------------------------
  // Sequencer. A query holds back its newest match so that the last one can be
  // flagged when the turn of the ring ends.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    opi_nxt        = opi_r;
    run_nxt        = run_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    stg_status_nxt = stg_status_r;
    stg_idx_nxt    = stg_idx_r;
    deg_nxt        = deg_r;
    quo_nxt        = quo_r;
    in_ready       = 1'b0;
    div_start      = 1'b0;
    add_load       = 1'b0;
    scan_adv       = 1'b0;
    push           = 1'b0;
    push_status    = STAT_CLEARED;
    push_idx       = '0;
    push_last      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_bus.valid) begin
          func_nxt   = in_bus.func;
          opi_nxt    = '0;
          run_nxt    = 1'b0;
          step_nxt   = '0;
          pend_v_nxt = 1'b0;
          unique case (in_bus.func)
            FUNC_CLEAR: begin
              count_nxt      = '0;
              stg_status_nxt = STAT_CLEARED;
              stg_idx_nxt    = '0;
              state_nxt      = ST_EMIT;
            end
            FUNC_ADD: begin
              if (count_r == CNT_W'(MAX_REGIONS)) begin
                stg_status_nxt = STAT_FULL;
                stg_idx_nxt    = '0;
                state_nxt      = ST_EMIT;
              end else begin
                deg_nxt[0] = lon_degrees(in_bus.box_lon_min);
                deg_nxt[1] = lon_degrees(in_bus.box_lon_max);
                deg_nxt[2] = lat_degrees(in_bus.box_lat_min);
                deg_nxt[3] = lat_degrees(in_bus.box_lat_max);
                state_nxt  = ST_DIV;
              end
            end
            FUNC_QUERY: begin
              deg_nxt[0] = lon_degrees(in_bus.point_lon);
              deg_nxt[1] = lat_degrees(in_bus.point_lat);
              state_nxt  = ST_DIV;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_DIV: begin
        if (!run_r) begin
          div_start = 1'b1;
          run_nxt   = 1'b1;
        end else if (div_stat.done) begin
          quo_nxt[opi_r] = div_stat.quo;
          run_nxt        = 1'b0;
          if (last_op) begin
            state_nxt = (func_r == FUNC_ADD) ? ST_ADD : ST_SCAN;
          end else begin
            opi_nxt = opi_r + 1'b1;
          end
        end
      end

      ST_ADD: begin
        add_load       = 1'b1;
        stg_status_nxt = STAT_ADDED;
        stg_idx_nxt    = count_r[IDX_W-1:0];
        count_nxt      = count_r + 1'b1;
        state_nxt      = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = stg_status_r;
          push_idx    = stg_idx_r;
          push_last   = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // The ring stops only when a new match must displace a held one and
        // the output register cannot take it.
        if (!(hit && pend_v_r && !out_free)) begin
          scan_adv = 1'b1;
          step_nxt = step_r + 1'b1;
          if (hit) begin
            if (pend_v_r) begin
              push        = 1'b1;
              push_status = STAT_MATCH;
              push_idx    = pend_idx_r;
            end
            pend_v_nxt   = 1'b1;
            pend_idx_nxt = step_r[IDX_W-1:0];
          end
          if (step_r == CNT_W'(MAX_REGIONS - 1)) begin
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          push        = 1'b1;
          push_status = pend_v_r ? STAT_MATCH : STAT_NO_MATCH;
          push_idx    = pend_v_r ? pend_idx_r : '0;
          push_last   = 1'b1;
          pend_v_nxt  = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = push ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= 1'b0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    opi_r        <= opi_nxt;
    step_r       <= step_nxt;
    pend_idx_r   <= pend_idx_nxt;
    stg_status_r <= stg_status_nxt;
    stg_idx_r    <= stg_idx_nxt;
    deg_r        <= deg_nxt;
    quo_r        <= quo_nxt;
    if (push) begin
      out_status_r <= push_status;
      out_idx_r    <= push_idx;
      out_last_r   <= push_last;
    end
  end

  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.region_index = out_idx_r;
  assign out_bus.last         = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `GBCI_ASSERT_NOW(a_push_no_overwrite, push, out_free, "result beat overwritten")
  `GBCI_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `GBCI_ASSERT_NOW(a_idle_no_pending, state_r == ST_IDLE, !pend_v_r, "held match left at idle")
  `GBCI_ASSERT_NEXT(a_add_counts, state_r == ST_ADD, count_r == $past(count_r) + 7'd1, "fill count slip")

endmodule

`default_nettype wire

FILE: rtl/gbci_cell.sv
// One cell of the region chain: holds the grid-cell ranges of one region.
// Depends on gbci_pkg for the box and control types.
`default_nettype none

module gbci_cell (
  input  logic                     clk,
  input  gbci_pkg::gbci_cell_ctl_t ctl,
  input  gbci_pkg::gbci_box_t      load_box,
  input  gbci_pkg::gbci_box_t      shift_in,
  output gbci_pkg::gbci_box_t      box
);
  import gbci_pkg::*;

  gbci_box_t box_r;

  // A load and a shift never come together; the load wins anyway.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      box_r <= load_box;
    end else if (ctl.shift) begin
      box_r <= shift_in;
    end
  end

  assign box = box_r;

endmodule

`default_nettype wire

FILE: rtl/gbci_div.sv
// Restoring divider, one quotient bit per cycle: whole degrees by cell size.
// Depends on gbci_pkg for widths and the status struct.
`default_nettype none

module gbci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gbci_pkg::DEG_W-1:0] dividend,
  input  logic [gbci_pkg::CS_W-1:0]  divisor,
  output gbci_pkg::gbci_div_stat_t   stat
);
  import gbci_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CS_W-1:0]      rem_r, rem_nxt;
  logic [DEG_W-1:0]     work_r, work_nxt;
  logic [CS_W-1:0]      dsr_r, dsr_nxt;
  logic [CS_W:0]        shifted;
  logic [CS_W:0]        diff;
  logic                 ge;

  assign shifted = {rem_r, work_r[DEG_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    dsr_nxt  = dsr_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      work_nxt = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so its low byte is all of it.
      rem_nxt  = ge ? diff[CS_W-1:0] : shifted[CS_W-1:0];
      work_nxt = {work_r[DEG_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quo  = work_r;

endmodule

`default_nettype wire
